// File: design/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsvrgb_pkg;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Hue scale: 1/64 degree units
    localparam logic [15:0] HUE_TURN   = 16'd23040;
    localparam logic [15:0] HUE_TURN2  = 16'd46080;
    localparam logic [11:0] HUE_SECTOR = 12'd3840;

    // Sector base hues for the 60 degree sectors
    localparam logic [14:0] BASE1 = 15'd3840;
    localparam logic [14:0] BASE2 = 15'd7680;
    localparam logic [14:0] BASE3 = 15'd11520;
    localparam logic [14:0] BASE4 = 15'd15360;
    localparam logic [14:0] BASE5 = 15'd19200;

    // floor(n / 15) = (n * RECIP15) >> 16, exact for n < 3840
    localparam logic [12:0] RECIP15 = 13'd4370;

    localparam logic [7:0] UNIT_MAX = 8'd255;

    // Sector codes
    localparam logic [2:0] SECT_RED     = 3'd0;
    localparam logic [2:0] SECT_YELLOW  = 3'd1;
    localparam logic [2:0] SECT_GREEN   = 3'd2;
    localparam logic [2:0] SECT_CYAN    = 3'd3;
    localparam logic [2:0] SECT_BLUE    = 3'd4;
    localparam logic [2:0] SECT_MAGENTA = 3'd5;

endpackage

// File: design/hsvrgb_pipe.sv
// Six-stage arithmetic pipeline for HSV to RGB conversion.
module hsvrgb_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  hsvrgb_pkg::hsv_t   in_data,
    output logic               out_valid,
    output hsvrgb_pkg::rgb_t   out_data
);

    // stage 1: hue wrap, v*s product
    logic        v1_reg;
    logic [14:0] h1_reg, h1_next;
    logic [15:0] p1_reg, p1_next;
    logic [7:0]  b1_reg;
    // stage 2: sector split, chroma estimate
    logic        v2_reg;
    logic [2:0]  sec2_reg, sec2_next;
    logic [11:0] frac2_reg, frac2_next;
    logic [7:0]  cest2_reg, cest2_next;
    logic [15:0] p2_reg;
    logic [7:0]  b2_reg;
    // stage 3: chroma corrected, slope operand
    logic        v3_reg;
    logic [7:0]  c3_reg, c3_next;
    logic [11:0] f3_reg, f3_next;
    logic [2:0]  sec3_reg;
    logic [7:0]  b3_reg;
    // stage 4: c*f product, offset m
    logic        v4_reg;
    logic [19:0] prod4_reg, prod4_next;
    logic [7:0]  c4_reg;
    logic [7:0]  m4_reg, m4_next;
    logic [2:0]  sec4_reg;
    // stage 5: divide by 3840
    logic        v5_reg;
    logic [7:0]  x5_reg, x5_next;
    logic [7:0]  c5_reg;
    logic [7:0]  m5_reg;
    logic [2:0]  sec5_reg;
    // stage 6: channel assignment
    logic        v6_reg;
    hsvrgb_pkg::rgb_t rgb6_reg, rgb6_next;

    logic [15:0] hue_wrap;
    logic [14:0] base2;
    logic [15:0] est_sum;
    logic [16:0] rem3;
    logic [24:0] recip5;
    logic [7:0]  cm6, xm6;

    // stage 1
    always_comb
    begin
        if (in_data.hue >= hsvrgb_pkg::HUE_TURN2)
            hue_wrap = in_data.hue - hsvrgb_pkg::HUE_TURN2;
        else if (in_data.hue >= hsvrgb_pkg::HUE_TURN)
            hue_wrap = in_data.hue - hsvrgb_pkg::HUE_TURN;
        else
            hue_wrap = in_data.hue;
        h1_next = hue_wrap[14:0];
        p1_next = {8'd0, in_data.brightness} * {8'd0, in_data.saturation};
    end

    // stage 2
    always_comb
    begin
        if (h1_reg >= hsvrgb_pkg::BASE5)
        begin
            sec2_next = hsvrgb_pkg::SECT_MAGENTA;
            base2     = hsvrgb_pkg::BASE5;
        end
        else if (h1_reg >= hsvrgb_pkg::BASE4)
        begin
            sec2_next = hsvrgb_pkg::SECT_BLUE;
            base2     = hsvrgb_pkg::BASE4;
        end
        else if (h1_reg >= hsvrgb_pkg::BASE3)
        begin
            sec2_next = hsvrgb_pkg::SECT_CYAN;
            base2     = hsvrgb_pkg::BASE3;
        end
        else if (h1_reg >= hsvrgb_pkg::BASE2)
        begin
            sec2_next = hsvrgb_pkg::SECT_GREEN;
            base2     = hsvrgb_pkg::BASE2;
        end
        else if (h1_reg >= hsvrgb_pkg::BASE1)
        begin
            sec2_next = hsvrgb_pkg::SECT_YELLOW;
            base2     = hsvrgb_pkg::BASE1;
        end
        else
        begin
            sec2_next = hsvrgb_pkg::SECT_RED;
            base2     = 15'd0;
        end
        frac2_next = 12'(h1_reg - base2);
        // p*257/65536 never overshoots p/255 and undershoots by at most one
        est_sum    = p1_reg + {8'd0, p1_reg[15:8]};
        cest2_next = est_sum[15:8];
    end

    // stage 3
    always_comb
    begin
        // remainder p - 255*est, below 510
        rem3 = {1'b0, p2_reg} + {9'd0, cest2_reg} - {1'b0, cest2_reg, 8'd0};
        if (rem3 >= {9'd0, hsvrgb_pkg::UNIT_MAX})
            c3_next = cest2_reg + 8'd1;
        else
            c3_next = cest2_reg;
        if (sec2_reg[0])
            f3_next = hsvrgb_pkg::HUE_SECTOR - frac2_reg;
        else
            f3_next = frac2_reg;
    end

    // stage 4
    always_comb
    begin
        prod4_next = {12'd0, c3_reg} * {8'd0, f3_reg};
        m4_next    = b3_reg - c3_reg;
    end

    // stage 5: /3840 = >>8 then /15
    always_comb
    begin
        recip5  = {13'd0, prod4_reg[19:8]} * {12'd0, hsvrgb_pkg::RECIP15};
        x5_next = recip5[23:16];
    end

    // stage 6
    always_comb
    begin
        cm6 = c5_reg + m5_reg;
        xm6 = x5_reg + m5_reg;
        case (sec5_reg)
            hsvrgb_pkg::SECT_RED:    rgb6_next = '{red: cm6, green: xm6, blue: m5_reg};
            hsvrgb_pkg::SECT_YELLOW: rgb6_next = '{red: xm6, green: cm6, blue: m5_reg};
            hsvrgb_pkg::SECT_GREEN:  rgb6_next = '{red: m5_reg, green: cm6, blue: xm6};
            hsvrgb_pkg::SECT_CYAN:   rgb6_next = '{red: m5_reg, green: xm6, blue: cm6};
            hsvrgb_pkg::SECT_BLUE:   rgb6_next = '{red: xm6, green: m5_reg, blue: cm6};
            default:                 rgb6_next = '{red: cm6, green: m5_reg, blue: xm6};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg    <= h1_next;
            p1_reg    <= p1_next;
            b1_reg    <= in_data.brightness;

            sec2_reg  <= sec2_next;
            frac2_reg <= frac2_next;
            cest2_reg <= cest2_next;
            p2_reg    <= p1_reg;
            b2_reg    <= b1_reg;

            c3_reg    <= c3_next;
            f3_reg    <= f3_next;
            sec3_reg  <= sec2_reg;
            b3_reg    <= b2_reg;

            prod4_reg <= prod4_next;
            c4_reg    <= c3_reg;
            m4_reg    <= m4_next;
            sec4_reg  <= sec3_reg;

            x5_reg    <= x5_next;
            c5_reg    <= c4_reg;
            m5_reg    <= m4_reg;
            sec5_reg  <= sec4_reg;

            rgb6_reg  <= rgb6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = rgb6_reg;

endmodule

// File: design/hsv_to_rgb_converter.sv
// Top level: HSV to RGB pixel converter with registered, skid-buffered output.
//
//  channel | direction | valid      | stall      | word
//  --------+-----------+------------+------------+-------------------------------
//  hsv     | in        | hsv_valid  | hsv_stall  | hue, saturation, brightness
//  rgb     | out       | rgb_valid  | rgb_stall  | red, green, blue
//
// Depth: 7 register stages (6 pipeline stages plus the output register) lie
// between the hsv word and the rgb word; one word per cycle sustained while
// rgb_stall stays low.
// The stage depth is set by the two constant-reciprocal divides (by 255 and
// by 3840) and the c*f multiply, each with a register after it.
// Reset clears all valid bits; no state survives between words.
// hsv_stall is the skid register's full flag, so a stall on rgb reaches the
// input only once the skid entry has absorbed the word in flight.
module hsv_to_rgb_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hsv_valid,
    output logic              hsv_stall,
    input  hsvrgb_pkg::hsv_t  hsv,
    output logic              rgb_valid,
    input  logic              rgb_stall,
    output hsvrgb_pkg::rgb_t  rgb
);

    logic             en;
    logic             pipe_valid;
    hsvrgb_pkg::rgb_t pipe_data;

    logic             out_valid_reg, out_valid_next;
    hsvrgb_pkg::rgb_t out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    hsvrgb_pkg::rgb_t skid_reg, skid_next;

    logic push;
    logic pop;

    assign en        = !skid_valid_reg;
    assign hsv_stall = skid_valid_reg;

    hsvrgb_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hsv_valid),
        .in_data   (hsv),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    assign push = en && pipe_valid;
    assign pop  = out_valid_reg && !rgb_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // pipeline is frozen; drain skid into output
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = pipe_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = pipe_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rgb_valid = out_valid_reg;
    assign rgb       = out_reg;

    // skid only ever holds a word behind a waiting output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output is empty");

    // a word arriving at a blocked output must land in the skid
    a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && rgb_stall && pipe_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("word lost at blocked output");

    // skid word is held while the output stays blocked
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && rgb_stall) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid word changed under stall");

    // output register drains the skid when taken
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !rgb_stall) |=> (rgb_valid && rgb == $past(skid_reg)))
        else $error("skid word not moved to output");

endmodule
